@@ src/hsskin_pkg.sv @@
// Package for the hue/saturation histogram skin classifier.
// Holds bin constants, the hue bin table and the controller/datapath command types.
// Depends on nothing; every other file of the block imports it.
package hsskin_pkg;

  localparam int HUE_BINS     = 90;
  localparam int SAT_BINS     = 110;
  localparam int COUNT_BITS   = 32;
  localparam int HUE_RANGE    = 180;
  localparam int NBINS        = HUE_BINS * SAT_BINS;
  localparam int ADDR_W       = $clog2(NBINS);
  localparam int HUE_BIN_W    = $clog2(HUE_BINS);
  localparam int SAT_BIN_W    = $clog2(SAT_BINS);
  localparam int SCALE_W      = 8;
  localparam int LIKE_W       = 8;
  localparam int PROD_W       = COUNT_BITS + SCALE_W;
  localparam int DIV_CNT_W    = $clog2(LIKE_W);
  localparam int KEEP_W       = 5;
  localparam int KEEP_MAX     = 16;
  localparam int PHASE_W      = $clog2(KEEP_MAX);
  localparam int SAMPLE_W     = 15;
  localparam int COUNTER_WRAP = 32000;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 8;

  localparam logic [1:0] KIND_TRAIN    = 2'd0;
  localparam logic [1:0] KIND_CLASSIFY = 2'd1;
  localparam logic [1:0] KIND_CLEAR    = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] REG_KEEP_EVERY  = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_RATIO_SCALE = CFG_INDEX_W'(1);

  localparam logic [KEEP_W-1:0]  KEEP_RESET  = KEEP_W'(2);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(255);

  typedef logic [255:0][HUE_BIN_W-1:0] hue_lut_t;

  function automatic hue_lut_t make_hue_lut();
    hue_lut_t lut;
    int v;
    for (int i = 0; i < 256; i++) begin
      v = (i * HUE_BINS) / HUE_RANGE;
      if (v >= HUE_BINS) begin
        v = HUE_BINS - 1;
      end
      lut[i] = HUE_BIN_W'(v);
    end
    return lut;
  endfunction

  localparam hue_lut_t HUE_LUT = make_hue_lut();

  typedef struct packed {
    logic                 load_bins;
    logic                 make_addr;
    logic                 read;
    logic                 clr_start;
    logic                 clr_write;
    logic                 train_write;
    logic                 is_skin;
    logic                 mul;
    logic                 cmp;
    logic                 div_step;
    logic [DIV_CNT_W-1:0] div_bit;
    logic                 load_out;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic decided;
    logic out_free;
  } dp_status_t;

endpackage

@@ src/hsskin_ctrl.sv @@
// Controller state machine of the skin classifier.
// Sequences clearing, training and classification and issues datapath commands.
// Depends on hsskin_pkg.
module hsskin_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic [1:0]             kind,
  input  logic                   skin_mask,
  output logic                   in_stall,
  input  hsskin_pkg::dp_status_t status,
  output hsskin_pkg::ctl_cmd_t   cmd
);
  import hsskin_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_INDEX, ST_READ, ST_WRITE, ST_MUL, ST_CMP, ST_DIV, ST_OUT
  } state_t;

  state_t               state;
  logic                 is_train;
  logic                 mask;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic                 accept;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      is_train <= 1'b0;
      mask     <= 1'b0;
      div_cnt  <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          if (status.clr_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            is_train <= (kind == KIND_TRAIN);
            mask     <= skin_mask;
            case (kind)
              KIND_TRAIN:    state <= ST_INDEX;
              KIND_CLASSIFY: state <= ST_INDEX;
              KIND_CLEAR:    state <= ST_CLEAR;
              default:       state <= ST_IDLE;
            endcase
          end
        end
        ST_INDEX: state <= ST_READ;
        ST_READ:  state <= is_train ? ST_WRITE : ST_MUL;
        ST_WRITE: state <= ST_IDLE;
        ST_MUL:   state <= ST_CMP;
        ST_CMP: begin
          div_cnt <= '0;
          state   <= status.decided ? ST_OUT : ST_DIV;
        end
        ST_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_CNT_W'(LIKE_W - 1)) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (status.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd             = '0;
    cmd.is_skin     = mask;
    cmd.div_bit     = ~div_cnt;
    cmd.load_bins   = accept;
    cmd.clr_start   = accept && (kind == KIND_CLEAR);
    cmd.clr_write   = (state == ST_CLEAR);
    cmd.make_addr   = (state == ST_INDEX);
    cmd.read        = (state == ST_READ);
    cmd.train_write = (state == ST_WRITE);
    cmd.mul         = (state == ST_MUL);
    cmd.cmp         = (state == ST_CMP);
    cmd.div_step    = (state == ST_DIV);
    cmd.load_out    = (state == ST_OUT) && status.out_free;
  end

endmodule

@@ src/hsskin_datapath.sv @@
// Datapath of the skin classifier: bin tables, sample counter, ratio divider, output register.
// Acts only on commands from hsskin_ctrl and reports status back to it.
// Depends on hsskin_pkg.
module hsskin_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  hsskin_pkg::ctl_cmd_t                cmd,
  output hsskin_pkg::dp_status_t              status,
  input  logic [7:0]                          hue,
  input  logic [7:0]                          saturation,
  input  logic                                cfg_write,
  input  logic [hsskin_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hsskin_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [hsskin_pkg::LIKE_W-1:0]       skin_likelihood
);
  import hsskin_pkg::*;

  logic [COUNT_BITS-1:0] skin_mem    [NBINS];
  logic [COUNT_BITS-1:0] nonskin_mem [NBINS];

  logic [KEEP_W-1:0]     keep_every;
  logic [SCALE_W-1:0]    ratio_scale;
  logic [HUE_BIN_W-1:0]  hue_bin;
  logic [SAT_BIN_W-1:0]  sat_bin;
  logic [ADDR_W-1:0]     addr;
  logic [ADDR_W-1:0]     clr_addr;
  logic [COUNT_BITS-1:0] rd_skin;
  logic [COUNT_BITS-1:0] rd_nonskin;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     rem;
  logic [LIKE_W-1:0]     quo;
  logic [SAMPLE_W-1:0]   sample_count;
  logic [PHASE_W-1:0]    phase [KEEP_MAX];

  logic [15:0]           sat_prod;
  logic [7:0]            sat_q;
  logic [SAT_BIN_W-1:0]  sat_bin_next;
  logic [KEEP_W-1:0]     keep_eff;
  logic [PHASE_W-1:0]    keep_sel;
  logic                  sample_hit;
  logic                  sample_adv;
  logic                  sample_wrap;
  logic                  skin_we;
  logic                  nonskin_we;
  logic [ADDR_W-1:0]     wr_addr;
  logic [COUNT_BITS-1:0] skin_wd;
  logic [COUNT_BITS-1:0] nonskin_wd;
  logic                  gt;
  logic                  ovf;
  logic [PROD_W-1:0]     trial;

  assign sat_prod     = 16'(saturation) * 16'(SAT_BINS);
  assign sat_q        = sat_prod[15:8];
  assign sat_bin_next = (sat_q >= 8'(SAT_BINS)) ? SAT_BIN_W'(SAT_BINS - 1)
                                                 : sat_q[SAT_BIN_W-1:0];

  always_comb begin
    keep_eff = keep_every;
    if (keep_every == '0) begin
      keep_eff = KEEP_W'(1);
    end else if (keep_every > KEEP_W'(KEEP_MAX)) begin
      keep_eff = KEEP_W'(KEEP_MAX);
    end
  end

  assign keep_sel    = PHASE_W'(keep_eff - KEEP_W'(1));
  assign sample_hit  = (phase[keep_sel] == '0);
  assign sample_adv  = cmd.train_write && !cmd.is_skin;
  assign sample_wrap = (sample_count == SAMPLE_W'(COUNTER_WRAP - 1));

  assign wr_addr    = cmd.clr_write ? clr_addr : addr;
  assign skin_we    = cmd.clr_write || (cmd.train_write && cmd.is_skin);
  assign nonskin_we = cmd.clr_write || (sample_adv && sample_hit);
  assign skin_wd    = cmd.clr_write ? '0
                                    : ((rd_skin == '1) ? rd_skin
                                                       : rd_skin + COUNT_BITS'(1));
  assign nonskin_wd = cmd.clr_write ? '0
                                    : ((rd_nonskin == '1) ? rd_nonskin
                                                          : rd_nonskin + COUNT_BITS'(1));

  assign gt    = (rd_skin > rd_nonskin);
  assign ovf   = (prod >= (PROD_W'(rd_nonskin) << SCALE_W));
  assign trial = PROD_W'(rd_nonskin) << cmd.div_bit;

  assign status.clr_last = (clr_addr == ADDR_W'(NBINS - 1));
  assign status.decided  = !gt || ovf;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (skin_we) begin
      skin_mem[wr_addr] <= skin_wd;
    end
    if (cmd.read) begin
      rd_skin <= skin_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (nonskin_we) begin
      nonskin_mem[wr_addr] <= nonskin_wd;
    end
    if (cmd.read) begin
      rd_nonskin <= nonskin_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keep_every   <= KEEP_RESET;
      ratio_scale  <= SCALE_RESET;
      clr_addr     <= '0;
      sample_count <= '0;
      out_valid    <= 1'b0;
      for (int j = 0; j < KEEP_MAX; j++) begin
        phase[j] <= '0;
      end
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_KEEP_EVERY:  keep_every  <= cfg_data[KEEP_W-1:0];
          REG_RATIO_SCALE: ratio_scale <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clr_start) begin
        clr_addr     <= '0;
        sample_count <= '0;
        for (int j = 0; j < KEEP_MAX; j++) begin
          phase[j] <= '0;
        end
      end else begin
        if (cmd.clr_write) begin
          clr_addr <= clr_addr + ADDR_W'(1);
        end
        if (sample_adv) begin
          sample_count <= sample_wrap ? '0 : sample_count + SAMPLE_W'(1);
          for (int j = 0; j < KEEP_MAX; j++) begin
            if (sample_wrap || (phase[j] == PHASE_W'(j))) begin
              phase[j] <= '0;
            end else begin
              phase[j] <= phase[j] + PHASE_W'(1);
            end
          end
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_bins) begin
      hue_bin <= HUE_LUT[hue];
      sat_bin <= sat_bin_next;
    end
    if (cmd.make_addr) begin
      addr <= ADDR_W'(ADDR_W'(hue_bin) * ADDR_W'(SAT_BINS) + ADDR_W'(sat_bin));
    end
    if (cmd.mul) begin
      prod <= PROD_W'(rd_skin) * PROD_W'(ratio_scale);
    end
    if (cmd.cmp) begin
      rem <= prod;
      quo <= (gt && ovf) ? '1 : '0;
    end
    if (cmd.div_step && (rem >= trial)) begin
      rem          <= rem - trial;
      quo[cmd.div_bit] <= 1'b1;
    end
    if (cmd.load_out) begin
      skin_likelihood <= quo;
    end
  end

endmodule

@@ src/hue_sat_histogram_skin_classifier.sv @@
// Top level of the hue/saturation histogram skin classifier.
// Joins the controller and the datapath; depends on hsskin_pkg, hsskin_ctrl, hsskin_datapath.
//
// The input channel (in_valid, in_stall) carries one pixel transaction: kind, hue, saturation
// and skin_mask. A train transaction bumps the skin or the sampled non-skin bin count, a
// classify transaction yields one skin_likelihood byte on the output channel (out_valid,
// out_stall), a clear transaction zeroes both tables and the sample counter, kind 3 is dropped.
// Items are handled one at a time. A train item steps through index, read and write states
// for the read-modify-write of the bin memories. A classify item runs index, read, multiply
// and compare states, then the eight-step ratio divider unless the compare already settles
// the result, and then loads its result; a kind 3 item ends as soon as it is accepted.
// After reset and after each clear transaction the block sweeps both tables, one bin a
// cycle, over all 9900 bins with in_stall high; configuration writes are taken at any time.
// The result sits in an output register; while out_stall holds it, the next item may be
// accepted and runs until its own result would need the register.
module hue_sat_histogram_skin_classifier (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         kind,
  input  logic [7:0]                         hue,
  input  logic [7:0]                         saturation,
  input  logic                               skin_mask,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [hsskin_pkg::LIKE_W-1:0]      skin_likelihood,
  input  logic                               cfg_write,
  input  logic [hsskin_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [hsskin_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import hsskin_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  hsskin_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .kind      (kind),
    .skin_mask (skin_mask),
    .in_stall  (in_stall),
    .status    (status),
    .cmd       (cmd)
  );

  hsskin_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .hue             (hue),
    .saturation      (saturation),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .skin_likelihood (skin_likelihood)
  );

endmodule

@@ src/hsskin_checker.sv @@
// Port-level checker for the skin classifier, bound to the top level.
// Depends on hsskin_pkg for kind codes and widths.
module hsskin_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         kind,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic [hsskin_pkg::LIKE_W-1:0]      skin_likelihood
);
  import hsskin_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(skin_likelihood))
    else $error("Stalled result changed or vanished.");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> in_stall)
    else $error("Input accepted during the table sweep after reset.");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (kind == KIND_TRAIN || kind == KIND_CLASSIFY ||
                              kind == KIND_CLEAR) |=> in_stall)
    else $error("Block took a new transaction while still working on one.");

  a_result_while_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("Result appeared without a transaction in progress.");

endmodule

bind hue_sat_histogram_skin_classifier hsskin_checker u_checker (.*);
